// ===== rtl/camera_time_window_synchronizer_defines.svh =====
// Assertion macros shared by the synchronizer RTL.
// Every user module must have clk_i and rst_ni (active low) in scope.
`ifndef CAMERA_TIME_WINDOW_SYNCHRONIZER_DEFINES_SVH
`define CAMERA_TIME_WINDOW_SYNCHRONIZER_DEFINES_SVH
`ifndef SYNTH
`define CTWS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ctws assertion failed");
`define CTWS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ctws assertion failed");
`else
`define CTWS_ASSERT_IMP(lbl, ante, cons)
`define CTWS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/ctws_pkg.sv =====
// Shared widths, codes and structs of the camera time-window synchronizer.
// No dependencies.
package ctws_pkg;

  localparam int unsigned ModeW    = 2;
  localparam int unsigned CamW     = 3;
  localparam int unsigned TsW      = 42;
  localparam int unsigned HandleW  = 32;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned FillW    = 4;
  localparam int unsigned KeepW    = 16;

  // stream packing
  localparam int unsigned InFieldW  = CamW + TsW + HandleW;
  localparam int unsigned InDataW   = ((InFieldW + 7) / 8) * 8;
  localparam int unsigned OutFieldW = TsW + CamW + 1 + HandleW + FillW;
  localparam int unsigned OutDataW  = ((OutFieldW + 7) / 8) * 8;

  // window rounding: remainder of (ts + 50) by 100, eight bits per cycle
  localparam int unsigned DigitW = 8;
  localparam int unsigned Digits = (TsW + 1 + DigitW - 1) / DigitW;
  localparam int unsigned RemW   = 7;

  localparam logic [KeepW-1:0] KeepReset = 16'd300;
  localparam logic [TsW:0]     RoundHalf = 43'd50;
  localparam logic [RemW:0]    WindowMs  = 8'd100;

  typedef enum logic [ModeW-1:0] {
    MODE_PUSH     = 2'd0,
    MODE_STRICT   = 2'd1,
    MODE_FALLBACK = 2'd2
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    STAT_STORED    = 3'd0,
    STAT_COMPLETE  = 3'd1,
    STAT_DUP       = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_SLOT      = 3'd4,
    STAT_NOT_READY = 3'd5,
    STAT_MISSING   = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_DROP,
    OP_SET,
    OP_ERASE
  } cell_op_e;

  // broadcast to every window cell
  typedef struct packed {
    cell_op_e         op;
    logic [TsW-1:0]   key;
    logic [KeepW-1:0] keep;
  } cell_cmd_t;

  // handed from cell to cell: has a cell to the left already matched / been free
  typedef struct packed {
    logic hit_seen;
    logic free_seen;
  } chain_t;

endpackage

// ===== rtl/ctws_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ctws_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ctws_rem.sv =====
// Window rounding unit: key = (ts + 50) - ((ts + 50) mod 100), one byte per cycle.
// Depends on ctws_pkg.
module ctws_rem import ctws_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [TsW-1:0] ts_i,
  output logic           done_o,
  output logic [TsW-1:0] key_o
);

  localparam int unsigned ShW  = DigitW * Digits;
  localparam int unsigned CntW = $clog2(Digits + 1);

  logic [ShW-1:0]  sh_q;
  logic [TsW:0]    x_q;
  logic [TsW:0]    x_in;
  logic [TsW:0]    diff;
  logic [RemW-1:0] r_q;
  logic [RemW-1:0] r_d;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;

  assign x_in = {1'b0, ts_i} + RoundHalf;

  // shift in one byte, keeping the running remainder below 100
  always_comb begin
    logic [RemW:0] acc;
    acc = {1'b0, r_q};
    for (int b = 0; b < DigitW; b++) begin
      acc = {acc[RemW-1:0], sh_q[ShW-1-b]};
      if (acc >= WindowMs) begin
        acc = acc - WindowMs;
      end
    end
    r_d = acc[RemW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CntW'(1);
      if (cnt_q == CntW'(Digits - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q <= ShW'(x_in);
      x_q  <= x_in;
      r_q  <= '0;
    end else if (busy_q) begin
      sh_q <= sh_q << DigitW;
      r_q  <= r_d;
    end
  end

  assign diff   = x_q - {{(TsW + 1 - RemW){1'b0}}, r_q};
  assign key_o  = diff[TsW-1:0];
  assign done_o = done_q;

endmodule

// ===== rtl/ctws_cell.sv =====
// One window entry of the table: valid bit, key, slot mask and fill count.
// Depends on ctws_pkg and the assertion macros header.
`include "camera_time_window_synchronizer_defines.svh"
module ctws_cell import ctws_pkg::*; #(
  parameter int unsigned CAMERAS = 8,
  localparam int unsigned CntW = $clog2(CAMERAS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cell_cmd_t          cmd_i,
  input  logic               sel_i,
  input  logic [CAMERAS-1:0] cam_oh_i,
  input  chain_t             chain_i,
  output chain_t             chain_o,
  input  logic [CAMERAS-1:0] mask_i,
  input  logic [CntW-1:0]    cnt_i,
  output logic [CAMERAS-1:0] mask_o,
  output logic [CntW-1:0]    cnt_o,
  output logic               hit_first_o,
  output logic               free_first_o
);

  logic               valid_q;
  logic [TsW-1:0]     key_q;
  logic [CAMERAS-1:0] mask_q;
  logic [CntW-1:0]    cnt_q;
  logic               hit;
  logic               stale;

  assign hit   = valid_q && (key_q == cmd_i.key);
  // entry + keep < key is the same as entry < key - keep, and never true when key < keep
  assign stale = valid_q &&
                 (({1'b0, key_q} + {{(TsW + 1 - KeepW){1'b0}}, cmd_i.keep}) < {1'b0, cmd_i.key});

  assign hit_first_o       = hit && !chain_i.hit_seen;
  assign free_first_o      = !valid_q && !chain_i.free_seen;
  assign chain_o.hit_seen  = chain_i.hit_seen | hit;
  assign chain_o.free_seen = chain_i.free_seen | !valid_q;
  assign mask_o            = hit_first_o ? mask_q : mask_i;
  assign cnt_o             = hit_first_o ? cnt_q : cnt_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      mask_q  <= '0;
      cnt_q   <= '0;
    end else begin
      case (cmd_i.op)
        OP_DROP: begin
          if (stale) begin
            valid_q <= 1'b0;
            mask_q  <= '0;
            cnt_q   <= '0;
          end
        end
        OP_SET: begin
          if (sel_i) begin
            valid_q <= 1'b1;
            mask_q  <= mask_q | cam_oh_i;
            cnt_q   <= cnt_q + CntW'(1);
          end
        end
        OP_ERASE: begin
          if (sel_i) begin
            valid_q <= 1'b0;
            mask_q  <= '0;
            cnt_q   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_SET && sel_i && !valid_q) begin
      key_q <= cmd_i.key;
    end
  end

  `CTWS_ASSERT_IMP(a_cnt_matches_mask, 1'b1, cnt_q == CntW'($countones(mask_q)))
  `CTWS_ASSERT_IMP(a_free_is_empty, !valid_q, mask_q == '0)
  `CTWS_ASSERT_IMP(a_set_fresh_slot, cmd_i.op == OP_SET && sel_i, (mask_q & cam_oh_i) == '0)

endmodule

// ===== rtl/camera_time_window_synchronizer.sv =====
// Camera time-window synchronizer: groups camera frame handles by 100 ms window.
// Row of ctws_cell entries, ctws_rem rounding unit, ctws_ram handle store; uses ctws_pkg.
//
// Usage:
//   s_axis carries one command per beat: tuser = mode (push, strict query,
//   fallback query), tdata = cam_id, timestamp_ms, payload_handle. m_axis
//   returns result beats: tuser = status, tdata = window key, slot, presence,
//   handle and fill count; tlast marks the final beat of a command. A push
//   gives one beat, a query of a held window gives CAMERAS beats, a query
//   that finds nothing ready gives one beat. Mode 3 is consumed silently.
//   cfg_data_i sets the keep span in ms; write it only while the block idles.
// Timing:
//   One command at a time. The timestamp rounding comes first (the
//   remainder unit works through the 43-bit sum one byte per cycle), then
//   the drop and table lookup states follow, one after the other. A push
//   then passes through ST_PUSH and ST_RES to the output register; a query
//   delivers its slots one per cycle while m_axis accepts them, paced by the
//   single read port of the handle RAM. The next command is taken once the
//   last result sits in the output register.
// Reset clears the table and sets the keep span to 300 ms. A stalled
// m_axis holds the output register and pauses delivery; nothing is dropped.
`include "camera_time_window_synchronizer_defines.svh"
module camera_time_window_synchronizer import ctws_pkg::*; #(
  parameter int unsigned CAMERAS = 8,
  parameter int unsigned WINDOWS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [2:0] cam_id, [44:3] timestamp_ms, [76:45] payload_handle, rest zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [1:0] mode
  input  logic [ModeW-1:0]    s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [41:0] window_key_ms, [44:42] slot_index, [45] present,
  // [77:46] slot_handle, [81:78] filled_slots, rest zero
  output logic [OutDataW-1:0] m_axis_tdata,
  // [2:0] status
  output logic [StatusW-1:0]  m_axis_tuser,
  output logic                m_axis_tlast,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [KeepW-1:0]    cfg_data_i
);

  localparam int unsigned CntW     = $clog2(CAMERAS + 1);
  localparam int unsigned WinIdxW  = $clog2(WINDOWS);
  localparam int unsigned SlotW    = (CAMERAS > 1) ? $clog2(CAMERAS) : 1;
  localparam int unsigned RamDepth = WINDOWS * CAMERAS;
  localparam int unsigned AddrW    = $clog2(RamDepth);
  localparam int unsigned TsLsb    = CamW;
  localparam int unsigned PayLsb   = CamW + TsW;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_DROP  = 3'd2;
  localparam logic [2:0] ST_LOOK  = 3'd3;
  localparam logic [2:0] ST_PUSH  = 3'd4;
  localparam logic [2:0] ST_DELIV = 3'd5;
  localparam logic [2:0] ST_RES   = 3'd6;

  logic [2:0]         state_q;
  logic [2:0]         state_d;
  logic [KeepW-1:0]   keep_q;

  mode_e              mode_q;
  logic [CamW-1:0]    cam_q;
  logic [HandleW-1:0] payload_q;
  logic               hit_q;
  logic               free_q;
  logic [WinIdxW-1:0] idx_q;
  logic [CAMERAS-1:0] mask_q;
  logic [CntW-1:0]    cnt_q;
  logic [SlotW-1:0]   slot_q;

  status_e            res_status_q;
  logic [CamW-1:0]    res_slot_q;
  logic               res_present_q;
  logic [HandleW-1:0] res_handle_q;
  logic [FillW-1:0]   res_fill_q;

  logic               out_valid_q;
  status_e            out_status_q;
  logic [TsW-1:0]     out_key_q;
  logic [CamW-1:0]    out_slot_q;
  logic               out_present_q;
  logic [HandleW-1:0] out_handle_q;
  logic [FillW-1:0]   out_fill_q;
  logic               out_last_q;

  mode_e              mode_in;
  logic               in_acc;
  logic               in_go;
  logic               rem_done;
  logic [TsW-1:0]     key_w;
  logic               out_free;

  cell_op_e           cell_op;
  cell_cmd_t          cmd;
  logic [WINDOWS-1:0] sel;
  logic [CAMERAS-1:0] cam_oh;
  chain_t             chain   [WINDOWS+1];
  logic [CAMERAS-1:0] mask_ch [WINDOWS+1];
  logic [CntW-1:0]    cnt_ch  [WINDOWS+1];
  logic [WINDOWS-1:0] hit_first;
  logic [WINDOWS-1:0] free_first;
  logic [WinIdxW-1:0] hit_idx;
  logic [WinIdxW-1:0] free_idx;
  logic               look_hit;
  logic               look_free;
  logic [WinIdxW-1:0] look_idx;
  logic               look_complete;

  logic               cam_ok;
  logic [CAMERAS-1:0] cam_bits;
  logic               push_dup;
  logic               push_store;
  logic [CntW-1:0]    cnt_inc;
  status_e            push_status;
  logic [HandleW-1:0] push_handle;
  logic [FillW-1:0]   push_fill;

  logic [CAMERAS-1:0] slot_bits;
  logic               slot_has;
  logic               slot_last;

  logic               ram_re;
  logic               ram_we;
  logic [AddrW-1:0]   ram_raddr;
  logic [AddrW-1:0]   ram_waddr;
  logic [AddrW-1:0]   look_addr;
  logic [AddrW-1:0]   deliv_addr;
  logic [HandleW-1:0] ram_rdata;

  logic               out_ld;
  status_e            ld_status;
  logic [CamW-1:0]    ld_slot;
  logic               ld_present;
  logic [HandleW-1:0] ld_handle;
  logic [FillW-1:0]   ld_fill;
  logic               ld_last;

  // ---------------------------------------------------------------- input side
  assign s_axis_tready = (state_q == ST_IDLE);
  assign mode_in       = mode_e'(s_axis_tuser);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_go         = in_acc && (mode_in == MODE_PUSH || mode_in == MODE_STRICT ||
                                    mode_in == MODE_FALLBACK);

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= KeepReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      keep_q <= cfg_data_i;
    end
  end

  ctws_rem u_rem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_go),
    .ts_i    (s_axis_tdata[TsLsb +: TsW]),
    .done_o  (rem_done),
    .key_o   (key_w)
  );

  // ---------------------------------------------------------------- window row
  assign cmd.op   = cell_op;
  assign cmd.key  = key_w;
  assign cmd.keep = keep_q;
  assign sel      = WINDOWS'(1) << idx_q;
  assign cam_oh   = CAMERAS'(1) << cam_q;

  assign chain[0]   = '0;
  assign mask_ch[0] = '0;
  assign cnt_ch[0]  = '0;

  for (genvar g = 0; g < WINDOWS; g++) begin : g_cell
    ctws_cell #(.CAMERAS(CAMERAS)) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .sel_i        (sel[g]),
      .cam_oh_i     (cam_oh),
      .chain_i      (chain[g]),
      .chain_o      (chain[g+1]),
      .mask_i       (mask_ch[g]),
      .cnt_i        (cnt_ch[g]),
      .mask_o       (mask_ch[g+1]),
      .cnt_o        (cnt_ch[g+1]),
      .hit_first_o  (hit_first[g]),
      .free_first_o (free_first[g])
    );
  end

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < WINDOWS; i++) begin
      if (hit_first[i]) begin
        hit_idx = hit_idx | WinIdxW'(i);
      end
      if (free_first[i]) begin
        free_idx = free_idx | WinIdxW'(i);
      end
    end
  end

  assign look_hit      = chain[WINDOWS].hit_seen;
  assign look_free     = chain[WINDOWS].free_seen;
  assign look_idx      = look_hit ? hit_idx : free_idx;
  assign look_complete = look_hit && (cnt_ch[WINDOWS] == CntW'(CAMERAS));

  // ---------------------------------------------------------------- push decision
  assign cam_ok      = 32'(cam_q) < CAMERAS;
  assign cam_bits    = mask_q >> cam_q;
  assign push_dup    = hit_q && cam_bits[0];
  assign push_store  = !push_dup && (hit_q || free_q);
  assign cnt_inc     = cnt_q + CntW'(1);

  always_comb begin
    if (push_dup) begin
      push_status = STAT_DUP;
      push_handle = ram_rdata;
      push_fill   = FillW'(cnt_q);
    end else if (push_store) begin
      push_status = (cnt_inc == CntW'(CAMERAS)) ? STAT_COMPLETE : STAT_STORED;
      push_handle = payload_q;
      push_fill   = FillW'(cnt_inc);
    end else begin
      push_status = STAT_FULL;
      push_handle = '0;
      push_fill   = '0;
    end
  end

  // ---------------------------------------------------------------- delivery
  assign slot_bits = mask_q >> slot_q;
  assign slot_has  = slot_bits[0];
  assign slot_last = (slot_q == SlotW'(CAMERAS - 1));

  assign look_addr  = AddrW'(look_idx) * AddrW'(CAMERAS) +
                      ((mode_q == MODE_PUSH) ? AddrW'(cam_q) : AddrW'(0));
  assign deliv_addr = AddrW'(idx_q) * AddrW'(CAMERAS) + AddrW'(slot_q + SlotW'(1));
  assign ram_waddr  = AddrW'(idx_q) * AddrW'(CAMERAS) + AddrW'(cam_q);

  ctws_ram #(.Width(HandleW), .Depth(RamDepth)) u_handles (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (payload_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free = !out_valid_q || m_axis_tready;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d    = state_q;
    cell_op    = OP_NOP;
    ram_re     = 1'b0;
    ram_raddr  = look_addr;
    ram_we     = 1'b0;
    out_ld     = 1'b0;
    ld_status  = res_status_q;
    ld_slot    = res_slot_q;
    ld_present = res_present_q;
    ld_handle  = res_handle_q;
    ld_fill    = res_fill_q;
    ld_last    = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (in_go) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_done) begin
          state_d = ST_DROP;
        end
      end
      ST_DROP: begin
        if (mode_q == MODE_PUSH) begin
          cell_op = OP_DROP;
        end
        state_d = ST_LOOK;
      end
      ST_LOOK: begin
        ram_re = 1'b1;
        case (mode_q)
          MODE_PUSH:     state_d = cam_ok ? ST_PUSH : ST_RES;
          MODE_STRICT:   state_d = look_complete ? ST_DELIV : ST_RES;
          MODE_FALLBACK: state_d = look_hit ? ST_DELIV : ST_RES;
          default:       state_d = ST_IDLE;
        endcase
      end
      ST_PUSH: begin
        if (push_store) begin
          cell_op = OP_SET;
          ram_we  = 1'b1;
        end
        state_d = ST_RES;
      end
      ST_DELIV: begin
        ld_status  = STAT_SLOT;
        ld_slot    = CamW'(slot_q);
        ld_present = slot_has;
        ld_handle  = slot_has ? ram_rdata : '0;
        ld_fill    = FillW'(cnt_q);
        ld_last    = slot_last;
        if (out_free) begin
          out_ld = 1'b1;
          if (slot_last) begin
            cell_op = OP_ERASE;
            state_d = ST_IDLE;
          end else begin
            // fetch the next slot while this one goes out
            ram_re    = 1'b1;
            ram_raddr = deliv_addr;
          end
        end
      end
      ST_RES: begin
        if (out_free) begin
          out_ld  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q    <= mode_in;
      cam_q     <= s_axis_tdata[CamW-1:0];
      payload_q <= s_axis_tdata[PayLsb +: HandleW];
    end
    if (state_q == ST_LOOK) begin
      hit_q         <= look_hit;
      free_q        <= look_free;
      idx_q         <= look_idx;
      mask_q        <= mask_ch[WINDOWS];
      cnt_q         <= cnt_ch[WINDOWS];
      slot_q        <= '0;
      res_slot_q    <= (mode_q == MODE_PUSH) ? cam_q : '0;
      res_present_q <= 1'b0;
      res_handle_q  <= '0;
      case (mode_q)
        MODE_PUSH: begin
          res_status_q <= STAT_FULL;
          res_fill_q   <= '0;
        end
        MODE_STRICT: begin
          res_status_q <= STAT_NOT_READY;
          res_fill_q   <= FillW'(cnt_ch[WINDOWS]);
        end
        default: begin
          res_status_q <= STAT_MISSING;
          res_fill_q   <= '0;
        end
      endcase
    end
    if (state_q == ST_PUSH) begin
      res_status_q  <= push_status;
      res_present_q <= push_dup || push_store;
      res_handle_q  <= push_handle;
      res_fill_q    <= push_fill;
    end
    if (state_q == ST_DELIV && out_free && !slot_last) begin
      slot_q <= slot_q + SlotW'(1);
    end
    if (out_ld) begin
      out_status_q  <= ld_status;
      out_key_q     <= key_w;
      out_slot_q    <= ld_slot;
      out_present_q <= ld_present;
      out_handle_q  <= ld_handle;
      out_fill_q    <= ld_fill;
      out_last_q    <= ld_last;
    end
  end

  // ---------------------------------------------------------------- output side
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{(OutDataW - OutFieldW){1'b0}}, out_fill_q, out_handle_q,
                          out_present_q, out_slot_q, out_key_q};

  `CTWS_ASSERT_IMP(a_deliv_needs_hit, state_q == ST_DELIV, hit_q)
  `CTWS_ASSERT_IMP(a_push_cam_in_range, state_q == ST_PUSH, cam_ok)
  `CTWS_ASSERT_NXT(a_push_then_result, state_q == ST_PUSH, state_q == ST_RES)

endmodule
